### rtl/rtha_pkg.sv
// Shared types and constants of the region table heap allocator.
package rtha_pkg;

  localparam int unsigned DEF_REGION_SLOTS     = 1024;
  localparam int unsigned DEF_PAGE_BYTES       = 4096;
  localparam int unsigned DEF_MIN_GROWTH_BYTES = 65536;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_TBL_FULL  = 3'd1;
  localparam logic [2:0] STS_NOT_ALLOC = 3'd2;
  localparam logic [2:0] STS_OVER_WIN  = 3'd3;
  localparam logic [2:0] STS_EXHAUSTED = 3'd4;

  localparam logic [1:0] WIN_NONE = 2'd0;
  localparam logic [1:0] WIN_PAGE = 2'd1;
  localparam logic [1:0] WIN_64K  = 2'd2;

  localparam logic [33:0] WIN_NONE_BYTES = 34'hFFFFFFFF;
  localparam logic [33:0] WIN_64K_BYTES  = 34'h10000;

  typedef struct packed {
    logic [31:0] bytes;
    logic        taken;
    logic [31:0] serial;
  } rtha_entry_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_START,
    ST_WALK_RD, ST_WALK_LD, ST_WALK_EV, ST_WALK_CK,
    ST_TAKE, ST_SHUP_RD, ST_SHUP_WR, ST_PGAP, ST_PTAKE, ST_PLEFT,
    ST_GROW_G, ST_GROW_RD, ST_GROW_LD, ST_GROW_CK,
    ST_FIND_RD, ST_FIND_LD, ST_FIND_CK, ST_NEXT_RD, ST_NEXT_LD, ST_MERGE,
    ST_SHDN_RD, ST_SHDN_WR, ST_DONE
  } rtha_state_e;

endpackage

### rtl/region_table_heap_allocator_unit.sv
// Steps: allocate walks each region from the cached start through read, load, evaluate and
// check states; growth sizes the step, reads and checks the last region, then evaluates it;
// a take then shifts each later region up by a read and a write and writes up to 3 entries;
// free and query walk each region from the base, and free then reads the next entry and
// shifts later regions down on a merge. Throughput: one request at a time, set by the single
// region table port. Reset: table empty, heap base 0, no clearing pass; ready at once.
module region_table_heap_allocator_unit
  import rtha_pkg::*;
#(
  parameter int unsigned REGION_SLOTS     = DEF_REGION_SLOTS,
  parameter int unsigned PAGE_BYTES       = DEF_PAGE_BYTES,
  parameter int unsigned MIN_GROWTH_BYTES = DEF_MIN_GROWTH_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] alloc_size_i,
  input  logic [23:0] align_bytes_i,
  input  logic        within_page_i,
  input  logic        within_64k_i,
  input  logic        need_contiguous_i,
  input  logic [31:0] block_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] result_address_o,
  output logic [31:0] block_bytes_o,
  output logic [31:0] alloc_serial_o
);

  localparam int unsigned IW = $clog2(REGION_SLOTS);
  localparam int unsigned CW = IW + 1;
  localparam logic [CW:0]   SLOTS_C = (CW+1)'(REGION_SLOTS);
  localparam logic [35:0]   PG_M    = 36'(PAGE_BYTES - 1);
  localparam logic [35:0]   MIN_G   = 36'(MIN_GROWTH_BYTES);
  localparam logic [33:0]   PG_B    = 34'(PAGE_BYTES);
  localparam logic [CW-1:0] ONE     = CW'(1);

  rtha_state_e state_q, state_d;

  // control state
  logic [CW-1:0] live_q, scan_idx_q;
  logic [32:0]   scan_addr_q;
  logic [31:0]   hb_q, serial_q, base_q;

  // request and working registers
  logic [1:0]  op_q, win_sel_q;
  logic [31:0] size_q, target_q;
  logic [23:0] align_q;
  logic        page_q, k64_q;
  logic [33:0] rsize_q, gap_q;
  logic [32:0] addr_q, nxt_addr_q, rem_q;
  logic [CW-1:0] i_q, j_q;
  logic        seen_free_q, growing_q;
  rtha_entry_t ent_q;
  logic [31:0] prev_bytes_q, nxt_bytes_q;
  logic        prev_taken_q, nxt_taken_q, has_next_q;
  logic [35:0] g_q;
  logic [1:0]  need_q, sh_q;
  logic        gapnz_q, left_q;
  logic [2:0]  res_status_q;
  logic [31:0] res_addr_q, res_bytes_q, res_serial_q;

  // RAM port
  logic              ram_we, ram_re;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  rtha_entry_t       ram_wdata, ram_rdata;

  rtha_ram #(.WIDTH($bits(rtha_entry_t)), .DEPTH(REGION_SLOTS)) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared datapath terms
  logic        win_fail, fit_ok, walk_more, last_free, grow_full, grow_exh;
  logic        left_c, gapnz_c, take_full, found, pf, nf, shdn_go;
  logic [1:0]  need_c, k_c;
  logic [CW-1:0] f_c, src_c;
  logic [32:0] faddr_c;
  logic [31:0] merge_sum;
  logic [33:0] a1, al, win_v;
  logic [35:0] r3, gt, gp, g_c;

  assign win_fail = (page_q && ({2'b0, size_q} > PG_B)) ||
                    (!page_q && k64_q && ({2'b0, size_q} > WIN_64K_BYTES));
  assign walk_more = ({1'b0, i_q} + 1'b1) < {1'b0, live_q};

  always_comb begin
    case (win_sel_q)
      WIN_PAGE: win_v = PG_B;
      WIN_64K:  win_v = WIN_64K_BYTES;
      default:  win_v = WIN_NONE_BYTES;
    endcase
  end

  assign fit_ok = !ent_q.taken && ({2'b0, ent_q.bytes} >= rsize_q + gap_q) &&
                  (win_v - {1'b0, rem_q} >= gap_q);

  assign a1 = {10'b0, align_q} - 34'd1;
  assign al = ({1'b0, addr_q} + a1) & ~a1;

  assign r3  = {2'b0, rsize_q} + {1'b0, rsize_q, 1'b0};
  assign gt  = (r3 >> 1) + PG_M;
  assign gp  = gt & ~PG_M;
  assign g_c = (gp < MIN_G) ? MIN_G : gp;

  assign last_free = (live_q != '0) && !ent_q.taken;
  assign grow_full = !last_free && ({1'b0, live_q} >= SLOTS_C);
  assign grow_exh  = ({4'b0, hb_q} + g_q > 36'hFFFFFFFF) ||
                     ({4'b0, base_q} + {4'b0, hb_q} + g_q > 36'h100000000);

  assign gapnz_c   = gap_q != '0;
  assign left_c    = ({2'b0, ent_q.bytes} - gap_q) > rsize_q;
  assign need_c    = {1'b0, gapnz_c} + {1'b0, left_c};
  assign take_full = ({1'b0, live_q} + {{(CW-1){1'b0}}, need_c}) > SLOTS_C;

  assign found = (addr_q == {1'b0, target_q}) && ent_q.taken;

  assign pf        = (i_q != '0) && !prev_taken_q;
  assign nf        = has_next_q && !nxt_taken_q;
  assign k_c       = {1'b0, pf} + {1'b0, nf};
  assign f_c       = pf ? i_q - ONE : i_q;
  assign faddr_c   = pf ? addr_q - {1'b0, prev_bytes_q} : addr_q;
  assign src_c     = f_c + ONE + {{(CW-2){1'b0}}, k_c};
  assign shdn_go   = (k_c != '0) && (src_c < live_q);
  assign merge_sum = ent_q.bytes + (nf ? nxt_bytes_q : 32'd0) + (pf ? prev_bytes_q : 32'd0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = ST_START;
      ST_START: begin
        case (op_q)
          REQ_ALLOC: begin
            if (win_fail)                  state_d = ST_DONE;
            else if (scan_idx_q < live_q)  state_d = ST_WALK_RD;
            else                           state_d = ST_GROW_G;
          end
          REQ_FREE, REQ_QUERY: begin
            if (target_q == '0 || live_q == '0) state_d = ST_DONE;
            else                                state_d = ST_FIND_RD;
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_WALK_RD: state_d = ST_WALK_LD;
      ST_WALK_LD: state_d = ST_WALK_EV;
      ST_WALK_EV: state_d = ST_WALK_CK;
      ST_WALK_CK: begin
        if (fit_ok)          state_d = ST_TAKE;
        else if (growing_q)  state_d = ST_GROW_RD;
        else if (walk_more)  state_d = ST_WALK_RD;
        else                 state_d = ST_GROW_G;
      end
      ST_GROW_G:  state_d = ST_GROW_RD;
      ST_GROW_RD: state_d = (live_q != '0) ? ST_GROW_LD : ST_GROW_CK;
      ST_GROW_LD: state_d = ST_GROW_CK;
      ST_GROW_CK: state_d = (grow_full || grow_exh) ? ST_DONE : ST_WALK_EV;
      ST_TAKE: begin
        if (take_full)             state_d = ST_DONE;
        else if (walk_more)        state_d = ST_SHUP_RD;
        else if (gapnz_c)          state_d = ST_PGAP;
        else                       state_d = ST_PTAKE;
      end
      ST_SHUP_RD: state_d = ST_SHUP_WR;
      ST_SHUP_WR: begin
        if (j_q == i_q + ONE) state_d = gapnz_q ? ST_PGAP : ST_PTAKE;
        else                  state_d = ST_SHUP_RD;
      end
      ST_PGAP:    state_d = ST_PTAKE;
      ST_PTAKE:   state_d = left_q ? ST_PLEFT : ST_DONE;
      ST_PLEFT:   state_d = ST_DONE;
      ST_FIND_RD: state_d = ST_FIND_LD;
      ST_FIND_LD: state_d = ST_FIND_CK;
      ST_FIND_CK: begin
        if (found) begin
          if (op_q == REQ_QUERY) state_d = ST_DONE;
          else if (walk_more)    state_d = ST_NEXT_RD;
          else                   state_d = ST_MERGE;
        end else begin
          state_d = walk_more ? ST_FIND_RD : ST_DONE;
        end
      end
      ST_NEXT_RD: state_d = ST_NEXT_LD;
      ST_NEXT_LD: state_d = ST_MERGE;
      ST_MERGE:   state_d = shdn_go ? ST_SHDN_RD : ST_DONE;
      ST_SHDN_RD: state_d = ST_SHDN_WR;
      ST_SHDN_WR: state_d = (j_q == live_q - ONE) ? ST_DONE : ST_SHDN_RD;
      ST_DONE:    if (out_ready_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // table port control
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = i_q[IW-1:0];
    ram_we    = 1'b0;
    ram_waddr = i_q[IW-1:0];
    ram_wdata = '0;
    case (state_q)
      ST_WALK_RD, ST_FIND_RD: ram_re = 1'b1;
      ST_GROW_RD: begin
        ram_re    = live_q != '0;
        ram_raddr = IW'(live_q - ONE);
      end
      ST_NEXT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = IW'(i_q + ONE);
      end
      ST_SHUP_RD, ST_SHDN_RD: begin
        ram_re    = 1'b1;
        ram_raddr = j_q[IW-1:0];
      end
      ST_SHUP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(j_q + {{(CW-2){1'b0}}, need_q});
        ram_wdata = ram_rdata;
      end
      ST_SHDN_WR: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(j_q - {{(CW-2){1'b0}}, sh_q});
        ram_wdata = ram_rdata;
      end
      ST_GROW_CK: begin
        ram_we = !grow_full && !grow_exh;
        if (last_free) begin
          ram_waddr = IW'(live_q - ONE);
          ram_wdata = '{bytes: ent_q.bytes + g_q[31:0], taken: 1'b0, serial: ent_q.serial};
        end else begin
          ram_waddr = live_q[IW-1:0];
          ram_wdata = '{bytes: g_q[31:0], taken: 1'b0, serial: 32'd0};
        end
      end
      ST_PGAP: begin
        ram_we    = 1'b1;
        ram_wdata = '{bytes: gap_q[31:0], taken: 1'b0, serial: 32'd0};
      end
      ST_PTAKE: begin
        ram_we    = 1'b1;
        ram_wdata = '{bytes: rsize_q[31:0], taken: 1'b1, serial: serial_q + 32'd1};
      end
      ST_PLEFT: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(i_q + ONE);
        ram_wdata = '{bytes: ent_q.bytes - gap_q[31:0] - rsize_q[31:0], taken: 1'b0,
                      serial: 32'd0};
      end
      ST_MERGE: begin
        ram_we    = 1'b1;
        ram_waddr = f_c[IW-1:0];
        ram_wdata = '{bytes: merge_sum, taken: 1'b0, serial: 32'd0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // allocator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q      <= '0;
      scan_idx_q  <= '0;
      scan_addr_q <= '0;
      hb_q        <= '0;
      serial_q    <= '0;
      base_q      <= '0;
    end else if (cfg_we_i) begin
      base_q      <= cfg_data_i;
      live_q      <= '0;
      scan_idx_q  <= '0;
      scan_addr_q <= {1'b0, cfg_data_i};
      hb_q        <= '0;
    end else begin
      case (state_q)
        ST_WALK_CK: begin
          // cache the last taken entry before the first free one
          if (!growing_q && ent_q.taken && !seen_free_q) begin
            scan_idx_q  <= i_q;
            scan_addr_q <= addr_q;
          end
        end
        ST_GROW_CK: begin
          if (!grow_full && !grow_exh) begin
            hb_q <= hb_q + g_q[31:0];
            if (!last_free) live_q <= live_q + ONE;
          end
        end
        ST_TAKE:  if (!take_full) live_q <= live_q + {{(CW-2){1'b0}}, need_c};
        ST_PTAKE: serial_q <= serial_q + 32'd1;
        ST_MERGE: begin
          if (f_c <= scan_idx_q) begin
            scan_idx_q  <= f_c;
            scan_addr_q <= faddr_c;
          end
          if (!shdn_go) live_q <= live_q - {{(CW-2){1'b0}}, k_c};
        end
        ST_SHDN_WR: if (j_q == live_q - ONE) live_q <= live_q - {{(CW-2){1'b0}}, sh_q};
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_q     <= req_type_i;
          size_q   <= alloc_size_i;
          align_q  <= align_bytes_i;
          page_q   <= within_page_i;
          k64_q    <= within_64k_i;
          target_q <= block_address_i;
        end
      end
      ST_START: begin
        rsize_q      <= ({2'b0, size_q} + 34'd3) & ~34'd3;
        win_sel_q    <= page_q ? WIN_PAGE : (k64_q ? WIN_64K : WIN_NONE);
        seen_free_q  <= 1'b0;
        growing_q    <= 1'b0;
        res_addr_q   <= '0;
        res_bytes_q  <= '0;
        res_serial_q <= '0;
        res_status_q <= STS_OK;
        if (op_q == REQ_ALLOC) begin
          i_q    <= scan_idx_q;
          addr_q <= scan_addr_q;
          if (win_fail) res_status_q <= STS_OVER_WIN;
        end else begin
          i_q    <= '0;
          addr_q <= {1'b0, base_q};
          if ((op_q == REQ_QUERY && target_q == '0) ||
              ((op_q == REQ_QUERY || op_q == REQ_FREE) && target_q != '0 &&
               live_q == '0)) begin
            res_status_q <= STS_NOT_ALLOC;
          end
        end
      end
      ST_WALK_LD, ST_FIND_LD, ST_GROW_LD: ent_q <= ram_rdata;
      ST_WALK_EV: begin
        gap_q      <= (align_q == '0) ? 34'd0 : al - {1'b0, addr_q};
        nxt_addr_q <= addr_q + {1'b0, ent_q.bytes};
        case (win_sel_q)
          WIN_PAGE: rem_q <= addr_q & PG_M[32:0];
          WIN_64K:  rem_q <= {17'b0, addr_q[15:0]};
          default:  rem_q <= (addr_q >= 33'hFFFFFFFF) ? addr_q - 33'hFFFFFFFF : addr_q;
        endcase
      end
      ST_WALK_CK: begin
        if (!growing_q && !ent_q.taken) seen_free_q <= 1'b1;
        if (!fit_ok && !growing_q) begin
          addr_q <= nxt_addr_q;
          i_q    <= i_q + ONE;
        end
      end
      ST_GROW_G:  g_q <= g_c;
      ST_GROW_RD: if (live_q == '0) ent_q.taken <= 1'b1;
      ST_GROW_CK: begin
        if (grow_full) begin
          res_status_q <= STS_TBL_FULL;
        end else if (grow_exh) begin
          res_status_q <= STS_EXHAUSTED;
        end else begin
          growing_q   <= 1'b1;
          ent_q.taken <= 1'b0;
          if (last_free) begin
            i_q         <= live_q - ONE;
            ent_q.bytes <= ent_q.bytes + g_q[31:0];
            addr_q      <= {1'b0, base_q} + {1'b0, hb_q} - {1'b0, ent_q.bytes};
          end else begin
            i_q          <= live_q;
            ent_q.bytes  <= g_q[31:0];
            ent_q.serial <= '0;
            addr_q       <= {1'b0, base_q} + {1'b0, hb_q};
          end
        end
      end
      ST_TAKE: begin
        need_q  <= need_c;
        gapnz_q <= gapnz_c;
        left_q  <= left_c;
        j_q     <= live_q - ONE;
        if (take_full) res_status_q <= STS_TBL_FULL;
      end
      ST_SHUP_WR: j_q <= j_q - ONE;
      ST_PGAP:    i_q <= i_q + ONE;
      ST_PTAKE: begin
        res_addr_q   <= addr_q[31:0] + gap_q[31:0];
        res_bytes_q  <= rsize_q[31:0];
        res_serial_q <= serial_q + 32'd1;
      end
      ST_FIND_CK: begin
        if (found) begin
          has_next_q <= walk_more;
          if (op_q == REQ_QUERY) res_bytes_q <= ent_q.bytes;
        end else begin
          prev_bytes_q <= ent_q.bytes;
          prev_taken_q <= ent_q.taken;
          addr_q       <= addr_q + {1'b0, ent_q.bytes};
          i_q          <= i_q + ONE;
          if (!walk_more) res_status_q <= STS_NOT_ALLOC;
        end
      end
      ST_NEXT_LD: begin
        nxt_bytes_q <= ram_rdata.bytes;
        nxt_taken_q <= ram_rdata.taken;
      end
      ST_MERGE: begin
        j_q  <= src_c;
        sh_q <= k_c;
      end
      ST_SHDN_WR: j_q <= j_q + ONE;
      default: ;
    endcase
  end

  assign in_ready_o       = state_q == ST_IDLE;
  assign out_valid_o      = state_q == ST_DONE;
  assign status_o         = res_status_q;
  assign result_address_o = res_addr_q;
  assign block_bytes_o    = res_bytes_q;
  assign alloc_serial_o   = res_serial_q;

`ifndef SYNTHESIS
  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, live_q} <= SLOTS_C) else $error("region count over table size");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STS_OK |-> result_address_o == '0 && alloc_serial_o == '0)
    else $error("failed request carries an address or serial");
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o && !out_valid_o)
    else $error("request not held busy");
  a_shift_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SHUP_WR || state_q == ST_SHDN_WR |-> j_q < live_q)
    else $error("shift outside live regions");
`endif

endmodule

### rtl/rtha_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rtha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### tb/sv/tb_region_table_heap_allocator_unit.sv
// Testbench for the region table heap allocator: directed table, random requests, predictor.
module tb_region_table_heap_allocator_unit;
  import rtha_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = DEF_REGION_SLOTS;
  localparam longint unsigned PAGE = DEF_PAGE_BYTES;
  localparam longint unsigned MIN_GROW = DEF_MIN_GROWTH_BYTES;
  localparam longint unsigned NO_WIN = 64'hFFFFFFFF;
  localparam longint unsigned WIN64 = 64'h10000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 20000000;

  // address source of a table row
  localparam int ADR_LIT = 0;
  localparam int ADR_LAST = 1;
  localparam int ADR_INSIDE = 2;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] size;
    logic [23:0] align;
    logic        wpage;
    logic        w64k;
    logic        contig;
    logic [31:0] addr;
  } heap_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] addr;
    logic [31:0] bytes;
    logic [31:0] serial;
  } heap_rsp_t;

  typedef struct {
    heap_req_t  req;
    int         amode;
    bit         typed;
    heap_rsp_t  rsp;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  req_type_i = '0;
  logic [31:0] alloc_size_i = '0;
  logic [23:0] align_bytes_i = '0;
  logic        within_page_i = 1'b0;
  logic        within_64k_i = 1'b0;
  logic        need_contiguous_i = 1'b0;
  logic [31:0] block_address_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b1;
  logic [2:0]  status_o;
  logic [31:0] result_address_o;
  logic [31:0] block_bytes_o;
  logic [31:0] alloc_serial_o;

  region_table_heap_allocator_unit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // allocator image kept by the predictor
  logic [31:0]     img_bytes [SLOTS];
  bit              img_taken [SLOTS];
  logic [31:0]     img_serial [SLOTS];
  int unsigned     img_live;
  int unsigned     img_scan_idx;
  longint unsigned img_scan_addr;
  logic [31:0]     img_heap;
  logic [31:0]     img_serial_ctr;
  logic [31:0]     img_base;

  heap_rsp_t   pending_rsp [$];
  logic [31:0] live_blocks [$];
  logic [31:0] last_block;
  int          fail_count;
  int          cycle_count;
  int          idle_pct;
  int          stall_pct;

  function automatic heap_rsp_t mk_rsp(logic [2:0] st, logic [31:0] a, logic [31:0] b,
                                       logic [31:0] s);
    heap_rsp_t r;
    r.status = st;
    r.addr = a;
    r.bytes = b;
    r.serial = s;
    return r;
  endfunction

  function automatic void img_open(int unsigned from);
    for (int unsigned j = img_live; j > from; j--) begin
      img_bytes[j] = img_bytes[j-1];
      img_taken[j] = img_taken[j-1];
      img_serial[j] = img_serial[j-1];
    end
    img_live++;
  endfunction

  function automatic void img_close(int unsigned at);
    for (int unsigned j = at; j + 1 < img_live; j++) begin
      img_bytes[j] = img_bytes[j+1];
      img_taken[j] = img_taken[j+1];
      img_serial[j] = img_serial[j+1];
    end
    img_live--;
  endfunction

  function automatic bit region_fits(int unsigned i, longint unsigned a, longint unsigned rsize,
                                     longint unsigned al, longint unsigned win,
                                     output longint unsigned gap);
    longint unsigned aa;
    aa = a;
    if (al != 0) aa = (a + al - 1) & ~(al - 1);
    gap = aa - a;
    return !img_taken[i] && longint'(img_bytes[i]) >= rsize + gap && win - (a % win) >= gap;
  endfunction

  function automatic heap_rsp_t region_take(int unsigned i, longint unsigned a,
                                            longint unsigned rsize, longint unsigned gap);
    int unsigned need;
    need = (gap != 0 ? 1 : 0) + ((longint'(img_bytes[i]) - gap) > rsize ? 1 : 0);
    if (img_live + need > SLOTS) return mk_rsp(STS_TBL_FULL, 0, 0, 0);
    if (gap != 0) begin
      img_open(i);
      img_bytes[i] = gap[31:0];
      img_taken[i] = 1'b0;
      img_serial[i] = 0;
      img_bytes[i+1] -= gap[31:0];
      i++;
      a += gap;
    end
    if (longint'(img_bytes[i]) > rsize) begin
      img_open(i + 1);
      img_bytes[i+1] = img_bytes[i] - rsize[31:0];
      img_taken[i+1] = 1'b0;
      img_serial[i+1] = 0;
      img_bytes[i] = rsize[31:0];
    end
    img_taken[i] = 1'b1;
    img_serial_ctr++;
    img_serial[i] = img_serial_ctr;
    return mk_rsp(STS_OK, a[31:0], rsize[31:0], img_serial_ctr);
  endfunction

  function automatic logic [2:0] img_extend(longint unsigned g);
    bit last_free;
    last_free = img_live > 0 && !img_taken[img_live-1];
    if (!last_free && img_live >= SLOTS) return STS_TBL_FULL;
    if (longint'(img_heap) + g > 64'hFFFFFFFF ||
        longint'(img_base) + img_heap + g > 64'h100000000) return STS_EXHAUSTED;
    if (last_free) begin
      img_bytes[img_live-1] += g[31:0];
    end else begin
      img_bytes[img_live] = g[31:0];
      img_taken[img_live] = 1'b0;
      img_serial[img_live] = 0;
      img_live++;
    end
    img_heap += g[31:0];
    return STS_OK;
  endfunction

  function automatic heap_rsp_t heap_alloc(heap_req_t q);
    longint unsigned sz, al, win, rsize, gap, a, g;
    bit seen_free;
    logic [2:0] st;
    int unsigned last;
    sz = q.size;
    al = q.align;
    win = NO_WIN;
    seen_free = 0;
    if (q.wpage) begin
      if (sz > PAGE) return mk_rsp(STS_OVER_WIN, 0, 0, 0);
      win = PAGE;
    end else if (q.w64k) begin
      if (sz > WIN64) return mk_rsp(STS_OVER_WIN, 0, 0, 0);
      win = WIN64;
    end
    rsize = (sz + 3) & ~64'd3;
    a = img_scan_addr;
    for (int unsigned i = img_scan_idx; i < img_live; i++) begin
      if (!img_taken[i]) begin
        seen_free = 1;
      end else if (!seen_free) begin
        img_scan_idx = i;
        img_scan_addr = a;
      end
      if (region_fits(i, a, rsize, al, win, gap)) return region_take(i, a, rsize, gap);
      a += img_bytes[i];
    end
    g = ((rsize * 3 / 2 + PAGE - 1) / PAGE) * PAGE;
    if (g < MIN_GROW) g = MIN_GROW;
    forever begin
      st = img_extend(g);
      if (st != STS_OK) return mk_rsp(st, 0, 0, 0);
      last = img_live - 1;
      a = longint'(img_base) + img_heap - img_bytes[last];
      if (region_fits(last, a, rsize, al, win, gap)) return region_take(last, a, rsize, gap);
    end
  endfunction

  function automatic heap_rsp_t heap_free(logic [31:0] target);
    longint unsigned a, fa;
    int unsigned f;
    a = img_base;
    if (target == 0) return mk_rsp(STS_OK, 0, 0, 0);
    for (int unsigned i = 0; i < img_live; i++) begin
      if (a == target && img_taken[i]) begin
        f = i;
        fa = a;
        img_taken[i] = 1'b0;
        img_serial[i] = 0;
        if (i + 1 < img_live && !img_taken[i+1]) begin
          img_bytes[i] += img_bytes[i+1];
          img_close(i + 1);
        end
        if (i > 0 && !img_taken[i-1]) begin
          fa = a - img_bytes[i-1];
          img_bytes[i-1] += img_bytes[i];
          img_close(i);
          f = i - 1;
        end
        if (f <= img_scan_idx) begin
          img_scan_idx = f;
          img_scan_addr = fa;
        end
        return mk_rsp(STS_OK, 0, 0, 0);
      end
      a += img_bytes[i];
    end
    return mk_rsp(STS_NOT_ALLOC, 0, 0, 0);
  endfunction

  function automatic heap_rsp_t heap_query(logic [31:0] target);
    longint unsigned a;
    a = img_base;
    if (target != 0) begin
      for (int unsigned i = 0; i < img_live; i++) begin
        if (a == target && img_taken[i]) return mk_rsp(STS_OK, 0, img_bytes[i], 0);
        a += img_bytes[i];
      end
    end
    return mk_rsp(STS_NOT_ALLOC, 0, 0, 0);
  endfunction

  function automatic heap_rsp_t heap_predict(heap_req_t q);
    heap_rsp_t r;
    case (q.kind)
      REQ_ALLOC: begin
        r = heap_alloc(q);
        if (r.status == STS_OK) begin
          last_block = r.addr;
          live_blocks.push_back(r.addr);
        end
      end
      REQ_FREE: r = heap_free(q.addr);
      REQ_QUERY: r = heap_query(q.addr);
      default: r = mk_rsp(STS_OK, 0, 0, 0);
    endcase
    return r;
  endfunction

  // hold the request until accepted, then maybe go idle
  task automatic send_req(heap_req_t q, bit typed, heap_rsp_t typed_rsp);
    heap_rsp_t r;
    in_valid_i <= 1'b1;
    req_type_i <= q.kind;
    alloc_size_i <= q.size;
    align_bytes_i <= q.align;
    within_page_i <= q.wpage;
    within_64k_i <= q.w64k;
    need_contiguous_i <= q.contig;
    block_address_i <= q.addr;
    do @(posedge clk_i); while (!in_ready_o);
    r = heap_predict(q);
    pending_rsp.push_back(typed ? typed_rsp : r);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_base(logic [31:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    img_base = v;
    img_live = 0;
    img_scan_idx = 0;
    img_scan_addr = v;
    img_heap = 0;
    live_blocks.delete();
  endtask

  function automatic heap_req_t rand_req();
    heap_req_t q;
    int r, k;
    q.kind = REQ_ALLOC;
    q.size = 0;
    q.align = 0;
    q.wpage = ($urandom_range(99) < 10);
    q.w64k = ($urandom_range(99) < 15);
    q.contig = 1'($urandom_range(1));
    q.addr = $urandom;
    r = $urandom_range(99);
    if (live_blocks.size() == 0 || r < (live_blocks.size() > 30 ? 30 : 50)) begin
      k = $urandom_range(99);
      if (k < 70) q.size = $urandom_range(0, 512);
      else if (k < 90) q.size = $urandom_range(513, 8192);
      else if (k < 98) q.size = $urandom_range(8193, 32'h30000);
      else q.size = $urandom;
      k = $urandom_range(99);
      if (k < 50) q.align = 0;
      else if (k < 85) q.align = 24'd1 << $urandom_range(0, 12);
      else if (k < 96) q.align = 24'($urandom_range(1, 64));
      else q.align = 24'($urandom_range(0, 24'hFFFFFF));
    end else if (r < 72 || r < 87) begin
      k = $urandom_range(live_blocks.size() - 1);
      q.kind = (r < 72) ? REQ_FREE : REQ_QUERY;
      q.addr = live_blocks[k];
      if (r < 72) live_blocks.delete(k);
    end else if (r < 95) begin
      // stray address: random, or inside a live block
      q.kind = $urandom_range(1) ? REQ_FREE : REQ_QUERY;
      if ($urandom_range(1)) q.addr = live_blocks[$urandom_range(live_blocks.size() - 1)] + 4;
    end else begin
      q.kind = $urandom_range(1) ? REQ_UNUSED : REQ_ALLOC;
      q.size = $urandom;
      q.align = 24'($urandom);
    end
    return q;
  endfunction

  // check responses against the oldest expectation
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
    if (out_valid_o && out_ready_i) begin
      if (pending_rsp.size() == 0) begin
        $error("response with nothing expected: status %0d", status_o);
        fail_count++;
      end else begin
        heap_rsp_t e;
        e = pending_rsp.pop_front();
        if (status_o !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status_o);
          fail_count++;
        end
        if (result_address_o !== e.addr) begin
          $error("result_address: expected %h, got %h", e.addr, result_address_o);
          fail_count++;
        end
        if (block_bytes_o !== e.bytes) begin
          $error("block_bytes: expected %h, got %h", e.bytes, block_bytes_o);
          fail_count++;
        end
        if (alloc_serial_o !== e.serial) begin
          $error("alloc_serial: expected %0d, got %0d", e.serial, alloc_serial_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic dir_row_t row(logic [1:0] kind, logic [31:0] size, logic [23:0] align,
                                   logic [2:0] flags, int amode, logic [31:0] addr,
                                   bit typed, heap_rsp_t rsp);
    dir_row_t d;
    d.req.kind = kind;
    d.req.size = size;
    d.req.align = align;
    d.req.wpage = flags[0];
    d.req.w64k = flags[1];
    d.req.contig = flags[2];
    d.req.addr = addr;
    d.amode = amode;
    d.typed = typed;
    d.rsp = rsp;
    return d;
  endfunction

  initial begin
    dir_row_t  dir [$];
    heap_rsp_t none;
    heap_rsp_t nf;
    heap_req_t q;
    int        bases [4];
    none = mk_rsp(STS_OK, 0, 0, 0);
    nf = mk_rsp(STS_NOT_ALLOC, 0, 0, 0);
    img_base = 0;
    img_live = 0;
    img_scan_idx = 0;
    img_scan_addr = 0;
    img_heap = 0;
    img_serial_ctr = 0;
    last_block = 0;
    fail_count = 0;
    cycle_count = 0;
    idle_pct = 0;
    stall_pct = 0;

    dir.push_back(row(REQ_QUERY, 0, 0, 3'b000, ADR_LIT, 0, 1, nf));
    dir.push_back(row(REQ_FREE, 0, 0, 3'b000, ADR_LIT, 0, 1, none));
    dir.push_back(row(REQ_FREE, 0, 0, 3'b000, ADR_LIT, 32'h1234, 1, nf));
    dir.push_back(row(REQ_ALLOC, 4097, 0, 3'b001, ADR_LIT, 0, 1,
                      mk_rsp(STS_OVER_WIN, 0, 0, 0)));
    dir.push_back(row(REQ_ALLOC, 32'h10001, 0, 3'b010, ADR_LIT, 0, 1,
                      mk_rsp(STS_OVER_WIN, 0, 0, 0)));
    dir.push_back(row(REQ_ALLOC, 5000, 0, 3'b011, ADR_LIT, 0, 1,
                      mk_rsp(STS_OVER_WIN, 0, 0, 0)));
    dir.push_back(row(REQ_UNUSED, 32'hFFFFFFFF, 24'hFFFFFF, 3'b111, ADR_LIT, 32'hFFFFFFFF, 1,
                      none));
    dir.push_back(row(REQ_ALLOC, 0, 0, 3'b000, ADR_LIT, 0, 1, mk_rsp(STS_OK, 0, 0, 1)));
    dir.push_back(row(REQ_ALLOC, 1, 0, 3'b000, ADR_LIT, 0, 1, mk_rsp(STS_OK, 0, 4, 2)));
    dir.push_back(row(REQ_ALLOC, 100, 64, 3'b000, ADR_LIT, 0, 0, none));
    dir.push_back(row(REQ_QUERY, 0, 0, 3'b000, ADR_LAST, 0, 0, none));
    dir.push_back(row(REQ_QUERY, 0, 0, 3'b000, ADR_INSIDE, 0, 0, none));
    dir.push_back(row(REQ_ALLOC, 3000, 4096, 3'b001, ADR_LIT, 0, 0, none));
    dir.push_back(row(REQ_ALLOC, 32'h10000, 24'h800, 3'b010, ADR_LIT, 0, 0, none));
    dir.push_back(row(REQ_ALLOC, 77, 6, 3'b100, ADR_LIT, 0, 0, none));
    dir.push_back(row(REQ_FREE, 0, 0, 3'b000, ADR_LAST, 0, 0, none));
    dir.push_back(row(REQ_FREE, 0, 0, 3'b000, ADR_LAST, 0, 1, nf));
    dir.push_back(row(REQ_ALLOC, 32'hFFFFFFFF, 0, 3'b000, ADR_LIT, 0, 1,
                      mk_rsp(STS_EXHAUSTED, 0, 0, 0)));
    dir.push_back(row(REQ_ALLOC, 32'hFFFFFF00, 24'hFFFFFF, 3'b100, ADR_LIT, 0, 1,
                      mk_rsp(STS_EXHAUSTED, 0, 0, 0)));
    dir.push_back(row(REQ_ALLOC, 32'h20000, 24'h800000, 3'b000, ADR_LIT, 0, 0, none));
    dir.push_back(row(REQ_QUERY, 0, 0, 3'b000, ADR_LAST, 0, 0, none));
    dir.push_back(row(REQ_ALLOC, 40, 0, 3'b000, ADR_LIT, 0, 0, none));
    dir.push_back(row(REQ_FREE, 0, 0, 3'b000, ADR_INSIDE, 0, 1, nf));
    dir.push_back(row(REQ_QUERY, 0, 0, 3'b000, ADR_LIT, 32'hFFFFFFFC, 1, nf));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir[n]) begin
      q = dir[n].req;
      if (dir[n].amode == ADR_LAST) q.addr = last_block;
      else if (dir[n].amode == ADR_INSIDE) q.addr = last_block + 4;
      send_req(q, dir[n].typed, dir[n].rsp);
    end

    bases[0] = 32'h1000_0000;
    bases[1] = 32'hFFFF_0000;
    bases[2] = $urandom & 32'hFFF0_0000;
    bases[3] = 32'hFFFF_FFFF;
    for (int ph = 0; ph < 4; ph++) begin
      set_base(bases[ph]);
      idle_pct = (ph == 1) ? 88 : (ph == 3) ? 30 : 0;
      stall_pct = (ph == 2) ? 88 : (ph == 3) ? 30 : 0;
      // the top-of-space base can only exhaust; move off it after a few requests
      for (int n = 0; n < 67; n++) begin
        if (ph == 3 && n == 12) set_base(0);
        if (ph == 0 && n == 33) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (pending_rsp.size() != 0) @(posedge clk_i);
        end
        send_req(rand_req(), 0, none);
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
